// File: sv/luma_scaled_block_watermark_embed_macros.svh
// Assertion helpers used by the watermark embedder RTL.
`ifndef LUMA_SCALED_BLOCK_WATERMARK_EMBED_MACROS_SVH
`define LUMA_SCALED_BLOCK_WATERMARK_EMBED_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LSBWE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSBWE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lsbwe_pkg.sv
`timescale 1ns / 1ps
package lsbwe_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int PIX_W     = 8;
   localparam int POWER_W   = 9;
   localparam int CHAN_W    = 2;
   localparam int DIM_CFG_W = 13;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   localparam logic [PHASE_W-1:0] BLOCK  = PHASE_W'(5);
   localparam logic [PHASE_W-1:0] CENTRE = PHASE_W'(2);

   localparam int COEF_W = 16;
   localparam int SUM_W  = 24;
   localparam logic [COEF_W-1:0] LUMA_R = COEF_W'(19595);
   localparam logic [COEF_W-1:0] LUMA_G = COEF_W'(38470);
   localparam logic [COEF_W-1:0] LUMA_B = COEF_W'(7471);

   localparam logic [CHAN_W-1:0] CH_RED   = CHAN_W'(0);
   localparam logic [CHAN_W-1:0] CH_GREEN = CHAN_W'(1);
   localparam logic [CHAN_W-1:0] CH_BLUE  = CHAN_W'(2);

   localparam logic [CSR_IDX_W-1:0] REG_POWER   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = CSR_IDX_W'(3);

   typedef struct packed {
      logic [PIX_W-1:0] in_red;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_blue;
      logic             message_bit;
      logic             bit_offered;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             bit_taken;
   } rsp_item_type;

   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic               message_bit;
      logic               embed;
      logic [CHAN_W-1:0]  chan;
      logic [POWER_W-1:0] power;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: sv/luma_scaled_block_watermark_embed.sv
`timescale 1ns / 1ps
// Luma-scaled block watermark embedder. Pixels enter in raster order, one
// transaction each; a front stage tracks the position modulo 5, marks 5x5 block
// centres and parks each pixel in a two-entry queue. A back-end sequencer takes
// one queued pixel at a time through dequeue, luma, strength and saturate steps
// and takes no new pixel until the last one is loaded into the output register.
// Results appear in input order from an output register. Configuration writes
// are accepted at any time (csr_ready is always high) and take effect
// immediately; write them only while no pixel is in flight.
module luma_scaled_block_watermark_embed #(
   parameter int MAX_DIM = lsbwe_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lsbwe_pkg::req_item_type           req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lsbwe_pkg::rsp_item_type           rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lsbwe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lsbwe_pkg::CSR_DAT_W-1:0]   csr_data
);
   import lsbwe_pkg::*;

   logic [POWER_W-1:0]   power_ff;
   logic [CHAN_W-1:0]    chan_ff;
   logic [DIM_CFG_W-1:0] width_ff;
   logic [DIM_CFG_W-1:0] height_ff;
   logic                 csr_write;
   queue_status_type     q_status;
   logic                 q_push;
   logic                 q_pop;
   job_type              q_job;
   job_type              q_head;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff  <= '0;
         chan_ff   <= CH_RED;
         width_ff  <= DIM_CFG_W'(4096);
         height_ff <= DIM_CFG_W'(4096);
      end else if (csr_write) begin
         case (csr_index)
            REG_POWER:   power_ff  <= csr_data[POWER_W-1:0];
            REG_CHANNEL: chan_ff   <= csr_data[CHAN_W-1:0];
            REG_WIDTH:   width_ff  <= csr_data[DIM_CFG_W-1:0];
            REG_HEIGHT:  height_ff <= csr_data[DIM_CFG_W-1:0];
            default:     power_ff  <= power_ff;
         endcase
      end
   end

   lsbwe_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .embed_power     (power_ff),
      .channel_select  (chan_ff),
      .image_width     (width_ff),
      .image_height    (height_ff),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_job           (q_job)
   );

   lsbwe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head_job (q_head),
      .status   (q_status)
   );

   lsbwe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// File: sv/lsbwe_queue.sv
`timescale 1ns / 1ps
module lsbwe_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lsbwe_pkg::job_type          push_job,
   input  logic                        pop,
   output lsbwe_pkg::job_type          head_job,
   output lsbwe_pkg::queue_status_type status
);
   import lsbwe_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: sv/lsbwe_front.sv
`timescale 1ns / 1ps
module lsbwe_front #(
   parameter int MAX_DIM = lsbwe_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lsbwe_pkg::req_item_type             req_item,
   input  logic [lsbwe_pkg::POWER_W-1:0]       embed_power,
   input  logic [lsbwe_pkg::CHAN_W-1:0]        channel_select,
   input  logic [lsbwe_pkg::DIM_CFG_W-1:0]     image_width,
   input  logic [lsbwe_pkg::DIM_CFG_W-1:0]     image_height,
   input  lsbwe_pkg::queue_status_type         q_status,
   output logic                                q_push,
   output lsbwe_pkg::job_type                  q_job
);
   import lsbwe_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CMP_W = ((DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W) + 1;

   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [PHASE_W-1:0] cph_ff, cph_in;
   logic [PHASE_W-1:0] rph_ff, rph_in;
   logic [CMP_W-1:0]   eff_w, eff_h;
   logic [CMP_W-1:0]   col_ext, row_ext;
   logic               centre;
   logic               chan_ok;

   always_comb begin
      if (image_width == '0) begin
         eff_w = CMP_W'(1);
      end else if (CMP_W'(image_width) > CMP_W'(MAX_DIM)) begin
         eff_w = CMP_W'(MAX_DIM);
      end else begin
         eff_w = CMP_W'(image_width);
      end
      if (image_height == '0) begin
         eff_h = CMP_W'(1);
      end else if (CMP_W'(image_height) > CMP_W'(MAX_DIM)) begin
         eff_h = CMP_W'(MAX_DIM);
      end else begin
         eff_h = CMP_W'(image_height);
      end
   end

   assign col_ext = CMP_W'(col_ff);
   assign row_ext = CMP_W'(row_ff);
   assign centre  = (cph_ff == CENTRE) && (rph_ff == CENTRE) &&
                    (col_ext + CMP_W'(BLOCK) <= eff_w) &&
                    (row_ext + CMP_W'(BLOCK) <= eff_h);
   assign chan_ok = channel_select inside {CH_RED, CH_GREEN, CH_BLUE};

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !req_stall;

   always_comb begin
      q_job.red         = req_item.in_red;
      q_job.green       = req_item.in_green;
      q_job.blue        = req_item.in_blue;
      q_job.message_bit = req_item.message_bit;
      q_job.embed       = centre && req_item.bit_offered && chan_ok;
      q_job.chan        = channel_select;
      q_job.power       = embed_power;
   end

   // advance raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cph_in = cph_ff;
      rph_in = rph_ff;
      if (q_push) begin
         if (col_ext + CMP_W'(1) >= eff_w) begin
            col_in = '0;
            cph_in = '0;
            if (row_ext + CMP_W'(1) >= eff_h) begin
               row_in = '0;
               rph_in = '0;
            end else begin
               row_in = row_ff + CNT_W'(1);
               rph_in = (rph_ff == BLOCK - PHASE_W'(1)) ? '0 : rph_ff + PHASE_W'(1);
            end
         end else begin
            col_in = col_ff + CNT_W'(1);
            cph_in = (cph_ff == BLOCK - PHASE_W'(1)) ? '0 : cph_ff + PHASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

endmodule

// File: sv/lsbwe_back.sv
`timescale 1ns / 1ps
`include "luma_scaled_block_watermark_embed_macros.svh"
module lsbwe_back (
   input  logic                        clock,
   input  logic                        reset,
   input  lsbwe_pkg::queue_status_type q_status,
   input  lsbwe_pkg::job_type          q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lsbwe_pkg::rsp_item_type     rsp_item
);
   import lsbwe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LUMA  = 4'b0010,
      ST_DELTA = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   job_type                job_ff;
   logic [PIX_W-1:0]       luma_ff;
   logic [POWER_W-1:0]     delta_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;
   logic [SUM_W-1:0]       luma_sum;
   logic [PIX_W+POWER_W-1:0] delta_prod;
   logic [PIX_W-1:0]       chan_val;
   logic [PIX_W-1:0]       chan_new;
   logic [POWER_W:0]       up_sum;
   logic                   out_free;
   logic                   load_out;

   assign q_pop    = (state_ff == ST_IDLE) && !q_status.empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_DONE) && out_free;

   assign luma_sum = SUM_W'(LUMA_R) * SUM_W'(job_ff.red) +
                     SUM_W'(LUMA_G) * SUM_W'(job_ff.green) +
                     SUM_W'(LUMA_B) * SUM_W'(job_ff.blue);
   assign delta_prod = (PIX_W + POWER_W)'(job_ff.power) * (PIX_W + POWER_W)'(luma_ff);

   always_comb begin
      case (job_ff.chan)
         CH_RED:   chan_val = job_ff.red;
         CH_GREEN: chan_val = job_ff.green;
         CH_BLUE:  chan_val = job_ff.blue;
         default:  chan_val = job_ff.red;
      endcase
      up_sum = (POWER_W + 1)'(chan_val) + (POWER_W + 1)'(delta_ff);
      if (job_ff.message_bit) begin
         chan_new = (up_sum > (POWER_W + 1)'(255)) ? 8'd255 : up_sum[PIX_W-1:0];
      end else begin
         chan_new = (delta_ff > POWER_W'(chan_val)) ? 8'd0 :
                    chan_val - delta_ff[PIX_W-1:0];
      end
   end

   always_comb begin
      rsp_item_in.out_red   = job_ff.red;
      rsp_item_in.out_green = job_ff.green;
      rsp_item_in.out_blue  = job_ff.blue;
      rsp_item_in.bit_taken = job_ff.embed;
      if (job_ff.embed) begin
         case (job_ff.chan)
            CH_RED:   rsp_item_in.out_red   = chan_new;
            CH_GREEN: rsp_item_in.out_green = chan_new;
            CH_BLUE:  rsp_item_in.out_blue  = chan_new;
            default:  rsp_item_in.bit_taken = 1'b0;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (q_pop) state_in = ST_LUMA;
         ST_LUMA:  state_in = ST_DELTA;
         ST_DELTA: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
      if (state_ff == ST_LUMA) begin
         luma_ff <= luma_sum[SUM_W-1:COEF_W];
      end
      if (state_ff == ST_DELTA) begin
         delta_ff <= delta_prod[PIX_W+POWER_W-1:PIX_W];
      end
      if (load_out) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `LSBWE_ASSERT_NOW(a_pop_idle, clock, reset, q_pop, state_ff == ST_IDLE, "pop outside idle")
   `LSBWE_ASSERT_NEXT(a_pop_starts, clock, reset, q_pop, state_ff == ST_LUMA, "pop did not start work")
   `LSBWE_ASSERT_NEXT(a_taken_flag, clock, reset, load_out,
      !rsp_item_ff.bit_taken || $past(job_ff.embed), "bit taken without embed")
   `LSBWE_ASSERT_NEXT(a_pass_through, clock, reset, load_out && !job_ff.embed,
      rsp_item_ff.out_red == $past(job_ff.red) && rsp_item_ff.out_blue == $past(job_ff.blue),
      "pass-through pixel changed")
   `LSBWE_ASSERT_NEXT(a_load_valid, clock, reset, load_out, rsp_valid_ff, "loaded result not valid")

endmodule
